@@ sv/adjacency_matrix_graph_traversal_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the graph traversal block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_TRAVERSAL_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_TRAVERSAL_MACROS_SVH

// Same-cycle implication.
`define AGT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/agt_pkg.sv @@
// ----------------------------------------------------------------------------
// agt_pkg
// Types, constants and helper functions of the graph traversal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package agt_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;
  localparam int CFG_W        = 5;
  localparam int USER_W       = 2;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic [USER_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [USER_W-1:0] MODE_BFS  = 2'd1;
  localparam logic [USER_W-1:0] MODE_DFS  = 2'd2;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    S_IDLE,
    S_BFS_CHK,
    S_DFS_CHK,
    S_BFETCH,
    S_BSCAN,
    S_DTOP,
    S_DSCAN,
    S_FINISH
  } step_t;

  // Condition tested by a step.
  typedef enum logic [2:0] {
    T_ALWAYS,
    T_IN_VALID,
    T_BFS_OK,
    T_DFS_OK,
    T_Q_AVAIL,
    T_CAND_ZERO,
    T_STACK_EMPTY
  } test_t;

  // Datapath action.
  typedef enum logic [2:0] {
    A_NONE,
    A_LATCH,
    A_INIT,
    A_FETCH_HEAD,
    A_FETCH_TOP,
    A_EMIT,
    A_POP,
    A_FINAL
  } act_t;

  typedef struct packed {
    test_t test;
    act_t  act_true;
    step_t next_true;
    act_t  act_false;
    step_t next_false;
  } ctrl_word_t;

  typedef struct packed {
    logic bfs_ok;
    logic dfs_ok;
    logic q_avail;
    logic cand_zero;
    logic stack_empty;
    logic out_free;
  } dp_status_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [VTX_W-1:0] lowest_index(input logic [MAX_VERTICES-1:0] x);
    logic [VTX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) idx = VTX_W'(i);
    end
    return idx;
  endfunction

  // One bit for each vertex below n.
  function automatic logic [MAX_VERTICES-1:0] span_mask(input logic [CNT_W-1:0] n);
    logic [MAX_VERTICES-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

@@ sv/adjacency_matrix_graph_traversal.sv @@
// Items: a load beat or a run request is taken only at the idle step, so the next item
// waits until the current one is done; a run waits while its result finds the output full.
// Reset: rst is synchronous, active high; it clears all edges, sets vertex_count to 16.
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal
// Breadth-first and depth-first traversal over a 16x16 adjacency bit matrix,
// run by a microcoded sequencer driving a plain datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacency_matrix_graph_traversal
  import agt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row[3:0], col[7:4], edge_present[8],
                                               // start_vertex[12:9], zero fill
  input  logic [USER_W-1:0]     s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // vertex[3:0], order_index[7:4],
                                               // all_reached[8], zero fill
  output logic                  m_axis_tlast,  // last
  // Configuration write channel (vertex_count).
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  // The step counter addresses the microprogram. Each control word names a
  // condition and, for either outcome, a datapath action and the next step.
  step_t      step;
  step_t      step_next;
  ctrl_word_t word;
  dp_status_t status;
  act_t       act_sel;
  act_t       act;
  logic       cond;
  logic       stall;

  agt_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  always_comb begin
    unique case (word.test)
      T_ALWAYS:      cond = 1'b1;
      T_IN_VALID:    cond = s_axis_tvalid;
      T_BFS_OK:      cond = status.bfs_ok;
      T_DFS_OK:      cond = status.dfs_ok;
      T_Q_AVAIL:     cond = status.q_avail;
      T_CAND_ZERO:   cond = status.cand_zero;
      T_STACK_EMPTY: cond = status.stack_empty;
      default:       cond = 1'b0;
    endcase
  end

  // Results go out through a single output register. A step that writes it
  // waits in place until that register is free, so nothing is lost.
  always_comb begin
    act_sel   = cond ? word.act_true  : word.act_false;
    step_next = cond ? word.next_true : word.next_false;
    stall     = ((act_sel == A_EMIT) || (act_sel == A_FINAL)) && !status.out_free;
    act       = stall ? A_NONE : act_sel;
    if (stall) step_next = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Items are taken only at the idle step; the final result of the previous
  // run may still sit in the output register at that time.
  assign s_axis_tready = (step == S_IDLE);
  assign cfg_ready     = 1'b1;

  agt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .status    (status)
  );

endmodule

@@ sv/agt_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// agt_ucode_rom
// Microprogram of the traversal sequencer, one control word per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agt_ucode_rom
  import agt_pkg::*;
(
  input  step_t      step,
  output ctrl_word_t word
);

  always_comb begin
    unique case (step)
      S_IDLE:    word = '{T_IN_VALID,    A_LATCH,      S_BFS_CHK, A_NONE,  S_IDLE};
      S_BFS_CHK: word = '{T_BFS_OK,      A_INIT,       S_BFETCH,  A_NONE,  S_DFS_CHK};
      S_DFS_CHK: word = '{T_DFS_OK,      A_INIT,       S_DTOP,    A_NONE,  S_IDLE};
      S_BFETCH:  word = '{T_Q_AVAIL,     A_FETCH_HEAD, S_BSCAN,   A_NONE,  S_FINISH};
      S_BSCAN:   word = '{T_CAND_ZERO,   A_NONE,       S_BFETCH,  A_EMIT,  S_BSCAN};
      S_DTOP:    word = '{T_STACK_EMPTY, A_NONE,       S_FINISH,  A_FETCH_TOP, S_DSCAN};
      S_DSCAN:   word = '{T_CAND_ZERO,   A_POP,        S_DTOP,    A_EMIT,  S_DTOP};
      S_FINISH:  word = '{T_ALWAYS,      A_FINAL,      S_IDLE,    A_FINAL, S_IDLE};
    endcase
  end

endmodule

@@ sv/agt_datapath.sv @@
// ----------------------------------------------------------------------------
// agt_datapath
// Adjacency rows, visited mask, vertex queue/stack and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agt_datapath
  import agt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  act_t                  act,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [USER_W-1:0]     in_user,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last,
  output dp_status_t            status
);

  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic [VTX_W-1:0]        pend [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] cand;
  logic [CNT_W-1:0]        head;
  logic [CNT_W-1:0]        tail;
  logic [CNT_W-1:0]        count;
  logic [CFG_W-1:0]        vcount;
  logic [USER_W-1:0]       mode;
  logic [VTX_W-1:0]        start;
  logic [VTX_W-1:0]        hold_vertex;
  logic [VTX_W-1:0]        hold_index;
  logic [VTX_W-1:0]        out_vertex;
  logic [VTX_W-1:0]        out_index;
  logic                    out_all;

  logic [CNT_W-1:0]        n_eff;
  logic [MAX_VERTICES-1:0] span;
  logic [CNT_W-1:0]        top;
  logic [VTX_W-1:0]        rd_addr;
  logic [VTX_W-1:0]        rd_vertex;
  logic [MAX_VERTICES-1:0] fetched;
  logic [VTX_W-1:0]        w;
  logic                    start_ok;

  logic [VTX_W-1:0] in_row, in_col, in_start;
  logic             in_edge;

  assign in_row   = in_data[3:0];
  assign in_col   = in_data[7:4];
  assign in_edge  = in_data[8];
  assign in_start = in_data[12:9];

  always_comb begin
    if (vcount == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(vcount) > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(vcount);
    end
  end

  assign span      = span_mask(n_eff);
  assign top       = tail - CNT_W'(1);
  assign rd_addr   = (act == A_FETCH_TOP) ? top[VTX_W-1:0] : head[VTX_W-1:0];
  assign rd_vertex = pend[rd_addr];
  assign fetched   = adj[rd_vertex] & span & ~visited;
  assign w         = lowest_index(cand);
  assign start_ok  = {1'b0, start} < n_eff;

  assign status.bfs_ok      = (mode == MODE_BFS) && start_ok;
  assign status.dfs_ok      = (mode == MODE_DFS) && start_ok;
  assign status.q_avail     = (head < tail) && !head[CNT_W-1];
  assign status.cand_zero   = (cand == '0);
  assign status.stack_empty = (tail == '0);
  assign status.out_free    = !out_valid || out_ready;

  assign out_data = {{(OUT_DATA_W - 2*VTX_W - 1){1'b0}}, out_all, out_index, out_vertex};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= CFG_RESET;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      visited   <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      // A new beat enters the output register as the old one leaves.
      if ((act == A_EMIT) || (act == A_FINAL)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (act)
        A_LATCH: begin
          if (in_user == MODE_LOAD) adj[in_row][in_col] <= in_edge;
        end
        A_INIT: begin
          visited <= MAX_VERTICES'(1) << start;
          count   <= CNT_W'(1);
          head    <= '0;
          tail    <= CNT_W'(1);
        end
        A_FETCH_HEAD: head <= head + CNT_W'(1);
        A_EMIT: begin
          visited[w] <= 1'b1;
          count      <= count + CNT_W'(1);
          if (!tail[CNT_W-1]) tail <= tail + CNT_W'(1);
        end
        A_POP: tail <= top;
        A_NONE, A_FETCH_TOP, A_FINAL: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (act)
      A_LATCH: begin
        mode  <= in_user;
        start <= in_start;
      end
      A_INIT: begin
        hold_vertex <= start;
        hold_index  <= '0;
        pend[0]     <= start;
      end
      A_FETCH_HEAD, A_FETCH_TOP: cand <= fetched;
      A_EMIT: begin
        cand[w]     <= 1'b0;
        out_vertex  <= hold_vertex;
        out_index   <= hold_index;
        out_last    <= 1'b0;
        out_all     <= 1'b0;
        hold_vertex <= w;
        hold_index  <= count[VTX_W-1:0];
        if (!tail[CNT_W-1]) pend[tail[VTX_W-1:0]] <= w;
      end
      A_FINAL: begin
        out_vertex <= hold_vertex;
        out_index  <= hold_index;
        out_last   <= 1'b1;
        out_all    <= (count == n_eff);
      end
      A_NONE, A_POP: ;
    endcase
  end

endmodule

@@ sv/agt_checker.sv @@
// ----------------------------------------------------------------------------
// agt_checker
// Port-level assertions for the graph traversal block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adjacency_matrix_graph_traversal_macros.svh"

module agt_checker
  import agt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
)
;

  // A stalled result beat keeps its contents.
  `AGT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  // The reached-all flag only rides on the final beat of a run.
  `AGT_ASSERT_NOW(a_all_on_last, m_axis_tvalid && !m_axis_tlast, !m_axis_tdata[8], "all_reached set on a non-final beat")

  // An accepted item always takes the sequencer out of its idle step.
  `AGT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready stayed high after a beat")

endmodule

bind adjacency_matrix_graph_traversal agt_checker u_agt_checker (.*);
